@@ rtl/core/etna_pkg.sv @@
// Shared types and constants for the element-to-node averaging block.
// Holds field widths, register indexes, command codes, the node entry
// type and the sequencer states. No dependencies.
package etna_pkg;

	// Field widths
	localparam int NODE_W  = 12;
	localparam int COL_W   = 6;
	localparam int VAL_W   = 32;
	localparam int CCNT_W  = 7;
	localparam int SUM_W   = 48;
	localparam int CNT_W   = 16;
	localparam int CIDX_W  = 8;
	localparam int CDATA_W = 8;

	// Parameter defaults
	localparam int NODE_COUNT_DEF        = 4096;
	localparam int MAX_CONTRIBUTIONS_DEF = 65535;

	// Configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_SELECTED_COLUMN = 8'd0;
	localparam logic [CIDX_W-1:0] CFG_COLUMN_COUNT    = 8'd1;

	// Reset values of the configuration registers
	localparam logic [COL_W-1:0]  SEL_RST  = 6'd0;
	localparam logic [CCNT_W-1:0] CCNT_RST = 7'd1;

	// Item commands
	localparam logic CMD_ACCUMULATE = 1'b0;
	localparam logic CMD_READ       = 1'b1;

	// One node entry: running sum and contribution count
	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [CNT_W-1:0]        cnt;
	} entry_t;

	// Divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

@@ rtl/core/etna_if.sv @@
// Channel interfaces of the element-to-node averaging block: input items,
// results and configuration writes, each with valid and ready.
// Depends on etna_pkg for field widths.
interface etna_item_if;
	logic                             valid;
	logic                             ready;
	logic                             command;
	logic [etna_pkg::NODE_W-1:0]      node;
	logic [etna_pkg::COL_W-1:0]       column;
	logic signed [etna_pkg::VAL_W-1:0] value;

	modport source (output valid, command, node, column, value, input ready);
	modport sink   (input valid, command, node, column, value, output ready);
endinterface

interface etna_result_if;
	logic                              valid;
	logic                              ready;
	logic signed [etna_pkg::VAL_W-1:0] average;
	logic                              empty_res;

	modport source (output valid, average, empty_res, input ready);
	modport sink   (input valid, average, empty_res, output ready);
endinterface

interface etna_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [etna_pkg::CIDX_W-1:0]   index;
	logic [etna_pkg::CDATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/etna_div.sv @@
// Bit-serial restoring divider: unsigned sum magnitude by contribution count,
// one quotient bit per cycle. Depends on etna_pkg for widths and the status type.
module etna_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [etna_pkg::SUM_W-1:0]   dividend,
	input  logic [etna_pkg::CNT_W-1:0]   divisor,
	output etna_pkg::div_status_t        status,
	output logic [etna_pkg::SUM_W-1:0]   quotient
);

	localparam int SW  = etna_pkg::SUM_W;
	localparam int CW  = etna_pkg::CNT_W;
	localparam int STW = $clog2(SW);
	localparam logic [STW-1:0] LAST_STEP = STW'(SW - 1);

	logic [SW-1:0]  dvd_q;
	logic [CW-1:0]  rem_q;
	logic [CW-1:0]  dsr_q;
	logic [STW-1:0] step_q;
	logic           busy_q;
	logic           done_q;

	logic [CW:0]    trial;
	logic [CW+1:0]  diff;
	logic           ge;

	// Shift in the next dividend bit and try the subtract
	assign trial = {rem_q, dvd_q[SW-1]};
	assign diff  = {1'b0, trial} - {2'b00, dsr_q};
	assign ge    = ~diff[CW+1];

	// Control: run SW steps after a start, then pulse done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: quotient bits shift into the low end of the dividend register
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SW-2:0], ge};
			rem_q <= ge ? diff[CW-1:0] : trial[CW-1:0];
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = dvd_q;

endmodule

@@ rtl/core/element_to_node_average.sv @@
// Element-to-node averaging: accumulate beats add a Q16.16 value of the
// selected column into a node's sum and count; read beats return the node's
// average (sum over count, truncated toward zero) and clear the entry. Sums
// and counts live in one NODE_COUNT-deep memory with a registered read port.
// After reset a clearing pass writes every entry once, and no item is taken
// until it ends; configuration writes are taken at any time. An accumulate
// reads the memory, then writes back. A read of an empty or out-of-range
// node skips the divider; any other read runs the bit-serial divider at one
// quotient bit per cycle over the 48-bit sum. A finished result waits in an
// output register while further accumulates proceed.
// Depends on etna_pkg, etna_if and etna_div.
module element_to_node_average #(
	parameter int NODE_COUNT        = etna_pkg::NODE_COUNT_DEF,
	parameter int MAX_CONTRIBUTIONS = etna_pkg::MAX_CONTRIBUTIONS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	etna_cfg_if.sink       cfg,
	etna_item_if.sink      item,
	etna_result_if.source  result
);

	localparam int NODE_AW = $clog2(NODE_COUNT);
	localparam int SW      = etna_pkg::SUM_W;
	localparam int CW      = etna_pkg::CNT_W;
	localparam int VW      = etna_pkg::VAL_W;
	localparam logic [NODE_AW-1:0] LAST_ADDR = NODE_AW'(NODE_COUNT - 1);
	localparam logic [CW-1:0]      CNT_LIMIT = CW'(MAX_CONTRIBUTIONS);

	// Configuration registers
	logic [etna_pkg::COL_W-1:0]  sel_q;
	logic [etna_pkg::CCNT_W-1:0] ccnt_q;

	// Sequencer and held item
	etna_pkg::state_t            state_q, state_d;
	logic [NODE_AW-1:0]          clr_addr_q;
	logic                        cmd_q;
	logic [NODE_AW-1:0]          addr_q;
	logic                        in_range_q;
	logic                        col_ok_q;
	logic signed [VW-1:0]        val_q;
	logic                        neg_q;
	logic signed [VW-1:0]        pend_avg_q;
	logic                        pend_empty_q;

	// Output register
	logic                        out_valid_q;
	logic signed [VW-1:0]        out_avg_q;
	logic                        out_empty_q;

	// Node memory
	etna_pkg::entry_t            mem_q [NODE_COUNT];
	etna_pkg::entry_t            rd_data_q;
	logic [NODE_AW-1:0]          rd_addr;
	logic                        mem_we;
	logic [NODE_AW-1:0]          mem_wa;
	etna_pkg::entry_t            mem_wd;

	// Divider hookup
	logic                        div_start;
	logic [SW-1:0]               div_dividend;
	etna_pkg::div_status_t       div_st;
	logic [SW-1:0]               div_quot;

	logic [etna_pkg::NODE_W+NODE_AW-1:0] node_wide;
	logic                        item_beat;
	logic                        out_free;
	logic signed [SW-1:0]        sum_next;
	logic                        acc_take;
	logic [VW-1:0]               quot_lo;

	assign item_beat = item.valid & item.ready;
	assign out_free  = ~out_valid_q | result.ready;
	assign node_wide = {{NODE_AW{1'b0}}, item.node};
	assign rd_addr   = node_wide[NODE_AW-1:0];

	// Configuration writes; unknown indexes are dropped
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q  <= etna_pkg::SEL_RST;
			ccnt_q <= etna_pkg::CCNT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				etna_pkg::CFG_SELECTED_COLUMN: sel_q  <= cfg.data[etna_pkg::COL_W-1:0];
				etna_pkg::CFG_COLUMN_COUNT:    ccnt_q <= cfg.data[etna_pkg::CCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	// Accumulate arithmetic on the entry just read
	assign sum_next = rd_data_q.sum + {{(SW-VW){val_q[VW-1]}}, val_q};
	assign acc_take = in_range_q & col_ok_q & (rd_data_q.cnt < CNT_LIMIT);
	assign div_dividend = rd_data_q.sum[SW-1] ? SW'(-rd_data_q.sum) : SW'(rd_data_q.sum);
	assign quot_lo = div_quot[VW-1:0];

	etna_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (rd_data_q.cnt),
		.status   (div_st),
		.quotient (div_quot)
	);

	// Sequencer: next state, memory write and divider start
	always_comb begin
		state_d    = state_q;
		mem_we     = 1'b0;
		mem_wa     = addr_q;
		mem_wd     = '0;
		div_start  = 1'b0;
		item.ready = 1'b0;
		unique case (state_q)
			etna_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_addr_q;
				if (clr_addr_q == LAST_ADDR) begin
					state_d = etna_pkg::ST_IDLE;
				end
			end
			etna_pkg::ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					state_d = etna_pkg::ST_LOOK;
				end
			end
			etna_pkg::ST_LOOK: begin
				if (cmd_q == etna_pkg::CMD_ACCUMULATE) begin
					mem_we     = acc_take;
					mem_wd.sum = sum_next;
					mem_wd.cnt = rd_data_q.cnt + 1'b1;
					state_d    = etna_pkg::ST_IDLE;
				end else if (!in_range_q || rd_data_q.cnt == '0) begin
					state_d = etna_pkg::ST_DONE;
				end else begin
					mem_we    = 1'b1;
					div_start = 1'b1;
					state_d   = etna_pkg::ST_DIV;
				end
			end
			etna_pkg::ST_DIV: begin
				if (div_st.done) begin
					state_d = etna_pkg::ST_DONE;
				end
			end
			etna_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = etna_pkg::ST_IDLE;
				end
			end
			default: state_d = etna_pkg::ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= etna_pkg::ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == etna_pkg::ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (item_beat) begin
			cmd_q      <= item.command;
			addr_q     <= rd_addr;
			in_range_q <= 32'(item.node) < 32'(NODE_COUNT);
			col_ok_q   <= (item.column == sel_q) && ({1'b0, sel_q} < ccnt_q);
			val_q      <= item.value;
		end
	end

	// Build the pending result: empty on the fast path, quotient after divide
	always_ff @(posedge clk) begin
		if (state_q == etna_pkg::ST_LOOK) begin
			neg_q        <= rd_data_q.sum[SW-1];
			pend_avg_q   <= '0;
			pend_empty_q <= 1'b1;
		end else if (state_q == etna_pkg::ST_DIV && div_st.done) begin
			pend_avg_q   <= neg_q ? -$signed(quot_lo) : $signed(quot_lo);
			pend_empty_q <= 1'b0;
		end
	end

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == etna_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == etna_pkg::ST_DONE && out_free) begin
			out_avg_q   <= pend_avg_q;
			out_empty_q <= pend_empty_q;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.average   = out_avg_q;
	assign result.empty_res = out_empty_q;

	// Checks
	a_accept_to_look: assert property (@(posedge clk) disable iff (!arst_n)
		item_beat |=> state_q == etna_pkg::ST_LOOK)
		else $error("accepted beat did not move to lookup");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> state_q == etna_pkg::ST_DIV)
		else $error("divider finished outside divide state");

	a_empty_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.empty_res) |-> result.average == '0)
		else $error("empty result carries a nonzero average");

	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == etna_pkg::ST_CLEAR |-> !result.valid && !item.ready)
		else $error("activity during clearing pass");

endmodule
